// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define AST_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define AST_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ===== hdl/lfsc_pkg.sv =====
package lfsc_pkg;

    // steering actions
    localparam logic [2:0] ACT_STRAIGHT = 3'd0;
    localparam logic [2:0] ACT_LEFT     = 3'd1;
    localparam logic [2:0] ACT_RIGHT    = 3'd2;
    localparam logic [2:0] ACT_BRAKE    = 3'd3;
    localparam logic [2:0] ACT_PIVOT    = 3'd4;
    localparam logic [2:0] ACT_FINE     = 3'd5;
    localparam logic [2:0] ACT_IDLE     = 3'd6;

    // register map
    localparam int unsigned REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_LINE_THRESHOLD = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_STOP_LEVEL     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DRIVE_SPEED    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PIVOT_SPEED    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_FINE_PIVOT     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_TIMEOUT_TICKS  = 3'd5;

    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned LEVEL_W    = 10;
    localparam int unsigned SPEED_W    = 8;
    localparam int unsigned TIMEOUT_W  = 16;
    localparam int unsigned VALUE_W    = 9;
    localparam int unsigned ACT_W      = 3;
    localparam int unsigned OUT_DATA_W = 16;

    localparam logic [LEVEL_W-1:0]   RST_LINE_THRESHOLD = 10'd100;
    localparam logic [LEVEL_W-1:0]   RST_STOP_LEVEL     = 10'd250;
    localparam logic [SPEED_W-1:0]   RST_DRIVE_SPEED    = 8'd120;
    localparam logic [SPEED_W-1:0]   RST_PIVOT_SPEED    = 8'd70;
    localparam logic [SPEED_W-1:0]   RST_FINE_PIVOT     = 8'd5;
    localparam logic [TIMEOUT_W-1:0] RST_TIMEOUT_TICKS  = 16'd40;

    typedef struct packed {
        logic [ACT_W-1:0]          action;
        logic signed [VALUE_W-1:0] drive_value;
        logic                      is_running;
        logic                      last;
    } t_result;

endpackage

// ===== hdl/line_follow_steering_controller.sv =====
// Channel | Dir | Handshake                  | Payload
// s_axis  | in  | s_axis_tvalid/tready       | tdata: left, right, center; tuser: start_req
// m_axis  | out | m_axis_tvalid/tready       | tdata: drive_value, is_running; tuser: action;
//         |     |                            | tlast: last_result
// cfg     | in  | i_cfg_valid/o_cfg_ready    | i_cfg_index, i_cfg_data
//
// One tick per clock while m_axis keeps up: an input register feeds a single
// pass of compare logic that writes the result register and the steering state
// in the same cycle. A tick that brakes or ends a correction yields two beats
// and holds the input register while the second beat drains from the pending
// slot. Stalls on m_axis back up through the pending slot and input register.
// i_rst_n is synchronous, active low; it restores register defaults and clears
// running, correcting, last side and the tick counter. Config is always ready.
`include "assert_macros.svh"

module line_follow_steering_controller #(
    parameter int unsigned SAMPLE_BITS     = 10,
    parameter int unsigned TICK_COUNT_BITS = 16,
    localparam int unsigned IN_DATA_W      = ((3 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // tick input
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata: left_sample, right_sample, center_sample (low to high), zero fill
    input  logic [IN_DATA_W-1:0]               s_axis_tdata,
    // tuser: start_req
    input  logic                               s_axis_tuser,
    // steering output
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata: drive_value[8:0], is_running[9], zero fill
    output logic [lfsc_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // tuser: action
    output logic [lfsc_pkg::ACT_W-1:0]         m_axis_tuser,
    output logic                               m_axis_tlast,
    // register writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [lfsc_pkg::REG_IDX_W-1:0]     i_cfg_index,
    input  logic [lfsc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import lfsc_pkg::*;

    localparam int unsigned SB   = SAMPLE_BITS;
    localparam int unsigned TCB  = TICK_COUNT_BITS;
    // contrast and threshold share one signed width with headroom for negation
    localparam int unsigned CMPW = ((SB > LEVEL_W) ? SB : LEVEL_W) + 2;
    localparam int unsigned LVW  = (SB > LEVEL_W) ? SB : LEVEL_W;
    localparam int unsigned CNTW = (TCB > TIMEOUT_W) ? TCB : TIMEOUT_W;

    // configuration
    logic [LEVEL_W-1:0]   r_line_threshold;
    logic [LEVEL_W-1:0]   r_stop_level;
    logic [SPEED_W-1:0]   r_drive_speed;
    logic [SPEED_W-1:0]   r_pivot_speed;
    logic [SPEED_W-1:0]   r_fine_pivot;
    logic [TIMEOUT_W-1:0] r_timeout_ticks;

    // steering state
    logic           r_running;
    logic           r_correcting;
    logic           r_last_right;
    logic [TCB-1:0] r_ticks;
    logic           n_running;
    logic           n_correcting;
    logic           n_last_right;
    logic [TCB-1:0] n_ticks;

    // input register
    logic          r_in_vld;
    logic          r_in_start;
    logic [SB-1:0] r_in_left;
    logic [SB-1:0] r_in_right;
    logic [SB-1:0] r_in_center;

    // output register plus one pending beat for two-beat ticks
    logic    r_out_vld;
    t_result r_out;
    logic    r_pend_vld;
    t_result r_pend;
    t_result n_first;
    t_result n_second;
    logic    n_two;

    logic out_take;
    logic advance;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_threshold <= RST_LINE_THRESHOLD;
            r_stop_level     <= RST_STOP_LEVEL;
            r_drive_speed    <= RST_DRIVE_SPEED;
            r_pivot_speed    <= RST_PIVOT_SPEED;
            r_fine_pivot     <= RST_FINE_PIVOT;
            r_timeout_ticks  <= RST_TIMEOUT_TICKS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_LINE_THRESHOLD: r_line_threshold <= i_cfg_data[LEVEL_W-1:0];
                REG_STOP_LEVEL:     r_stop_level     <= i_cfg_data[LEVEL_W-1:0];
                REG_DRIVE_SPEED:    r_drive_speed    <= i_cfg_data[SPEED_W-1:0];
                REG_PIVOT_SPEED:    r_pivot_speed    <= i_cfg_data[SPEED_W-1:0];
                REG_FINE_PIVOT:     r_fine_pivot     <= i_cfg_data[SPEED_W-1:0];
                REG_TIMEOUT_TICKS:  r_timeout_ticks  <= i_cfg_data[TIMEOUT_W-1:0];
                default: ;
            endcase
        end
    end

    // handshake
    assign out_take      = r_out_vld && m_axis_tready;
    assign advance       = r_in_vld && !r_pend_vld && (!r_out_vld || out_take);
    assign s_axis_tready = !r_in_vld || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_start  <= s_axis_tuser;
            r_in_left   <= s_axis_tdata[SB-1:0];
            r_in_right  <= s_axis_tdata[2*SB-1:SB];
            r_in_center <= s_axis_tdata[3*SB-1:2*SB];
        end
    end

    // side classification; a contrast equal to the threshold is a hit
    logic signed [CMPW-1:0] contrast;
    logic signed [CMPW-1:0] thr_s;
    logic                   hit_left;
    logic                   hit_right;
    logic                   hit;
    logic                   run_now;
    logic                   stop;
    logic                   opposite;
    logic [TCB-1:0]         ticks_inc;
    logic [TCB-1:0]         ticks_follow;
    logic                   timed_out;
    logic signed [VALUE_W-1:0] pivot_val;
    logic signed [VALUE_W-1:0] fine_val;
    logic signed [VALUE_W-1:0] speed_val;

    assign contrast  = $signed({{(CMPW-SB){1'b0}}, r_in_left})
                     - $signed({{(CMPW-SB){1'b0}}, r_in_right});
    assign thr_s     = $signed({{(CMPW-LEVEL_W){1'b0}}, r_line_threshold});
    assign hit_left  = contrast >= thr_s;
    assign hit_right = !hit_left && (contrast <= -thr_s);
    assign hit       = hit_left || hit_right;
    assign run_now   = r_running || r_in_start;
    assign stop      = LVW'(r_in_center) > LVW'(r_stop_level);
    assign opposite  = hit && (hit_right != r_last_right);

    assign ticks_inc    = (r_ticks == {TCB{1'b1}}) ? r_ticks : r_ticks + 1'b1;
    assign ticks_follow = hit ? '0 : ticks_inc;
    assign timed_out    = CNTW'(ticks_follow) > CNTW'(r_timeout_ticks);

    assign speed_val = $signed({1'b0, r_drive_speed});
    assign pivot_val = r_last_right ? $signed({1'b0, r_pivot_speed})
                                    : -$signed({1'b0, r_pivot_speed});
    assign fine_val  = hit_right ? $signed({1'b0, r_fine_pivot})
                                 : -$signed({1'b0, r_fine_pivot});

    always_comb begin
        n_running    = r_running;
        n_correcting = r_correcting;
        n_last_right = r_last_right;
        n_ticks      = r_ticks;
        n_two        = 1'b0;
        n_first      = '{action: ACT_IDLE, drive_value: '0, is_running: 1'b0, last: 1'b1};
        n_second     = '{action: ACT_BRAKE, drive_value: '0, is_running: 1'b0, last: 1'b1};
        if (run_now) begin
            n_running = 1'b1;
            if (r_correcting) begin
                n_first = '{action: ACT_PIVOT, drive_value: pivot_val,
                            is_running: 1'b1, last: !opposite};
                if (hit) begin
                    n_ticks = '0;
                end
                if (opposite) begin
                    n_two        = 1'b1;
                    n_last_right = hit_right;
                    n_correcting = 1'b0;
                    n_second     = '{action: ACT_FINE, drive_value: fine_val,
                                     is_running: 1'b1, last: 1'b1};
                end
            end else begin
                n_ticks      = ticks_follow;
                n_correcting = timed_out;
                if (hit) begin
                    n_last_right = hit_right;
                end
                n_first.action      = hit_left ? ACT_LEFT :
                                      (hit_right ? ACT_RIGHT : ACT_STRAIGHT);
                n_first.drive_value = speed_val;
                n_first.is_running  = 1'b1;
                n_first.last        = !stop;
                if (stop) begin
                    n_two     = 1'b1;
                    n_running = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running    <= 1'b0;
            r_correcting <= 1'b0;
            r_last_right <= 1'b0;
            r_ticks      <= '0;
        end else if (advance) begin
            r_running    <= n_running;
            r_correcting <= n_correcting;
            r_last_right <= n_last_right;
            r_ticks      <= n_ticks;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_pend_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld  <= 1'b1;
            r_pend_vld <= n_two;
        end else if (out_take) begin
            r_out_vld  <= r_pend_vld;
            r_pend_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out  <= n_first;
            r_pend <= n_second;
        end else if (out_take) begin
            r_out  <= r_pend;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser  = r_out.action;
    assign m_axis_tlast  = r_out.last;
    assign m_axis_tdata  = {{(OUT_DATA_W-VALUE_W-1){1'b0}}, r_out.is_running,
                            r_out.drive_value};

    // a first beat that is not last always has its partner waiting behind it
    `AST_CHECK(a_pend_pairs, r_out_vld && !r_out.last |-> r_pend_vld, "pending beat missing")
    `AST_CHECK(a_pend_behind, r_pend_vld |-> r_out_vld && !r_out.last, "pending beat misplaced")
    `AST_CHECK(a_idle_stopped, r_out_vld && r_out.action == ACT_IDLE |-> !r_out.is_running && r_out.last, "idle beat while running")
    `AST_CHECK(a_brake_stops, r_out_vld && r_out.action == ACT_BRAKE |-> !r_out.is_running && r_out.last, "brake beat malformed")
    `AST_ALWAYS(a_no_pend_alone, !r_out_vld |-> !r_pend_vld, "pending beat without output")

endmodule
